// ===== hw/rtl/fqp_pkg.sv =====
// fqp_pkg: shared types and constants for the fifo queue with peek
// no dependencies; imported by every module of the block
package fqp_pkg;

  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned SIZE_W = $clog2(DEPTH + 1);

  localparam logic [1:0] FUNC_PUSH  = 2'd0;
  localparam logic [1:0] FUNC_POP   = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  localparam logic signed [WORD_W-1:0] NEG_ONE = '1;
  localparam logic [SIZE_W-1:0]        FULL_COUNT = SIZE_W'(DEPTH);

  typedef struct packed {
    logic [1:0]               func;
    logic signed [WORD_W-1:0] data;
  } fqp_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] pop_value;
    logic [SIZE_W-1:0]        size;
    logic                     empty_res;
    logic signed [WORD_W-1:0] front;
    logic signed [WORD_W-1:0] back;
    logic                     dropped;
  } fqp_out_t;

  // control from the top level to the row of cells
  typedef struct packed {
    logic                     shift;
    logic                     load;
    logic [SIZE_W-1:0]        load_idx;
    logic signed [WORD_W-1:0] load_data;
  } fqp_ctrl_t;

  // the two words nearest the front of the row
  typedef struct packed {
    logic signed [WORD_W-1:0] w0;
    logic signed [WORD_W-1:0] w1;
  } fqp_peek_t;

endpackage

// ===== hw/rtl/fqp_cell.sv =====
// fqp_cell: one storage cell of the queue row
// depends on fqp_pkg
module fqp_cell
  import fqp_pkg::*;
(
  input  logic                     clk,
  input  logic                     shift_en,
  input  logic                     load_en,
  input  logic signed [WORD_W-1:0] load_data,
  input  logic signed [WORD_W-1:0] next_word,
  output logic signed [WORD_W-1:0] word
);

  logic signed [WORD_W-1:0] word_r;

  always_ff @(posedge clk) begin
    if (load_en) begin
      word_r <= load_data;
    end else if (shift_en) begin
      word_r <= next_word;
    end
  end

  assign word = word_r;

endmodule

// ===== hw/rtl/fqp_chain.sv =====
// fqp_chain: row of DEPTH cells, position 0 holds the oldest word
// depends on fqp_pkg and fqp_cell
module fqp_chain
  import fqp_pkg::*;
(
  input  logic      clk,
  input  fqp_ctrl_t ctrl,
  output fqp_peek_t peek
);

  logic signed [WORD_W-1:0] words [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] nbr;
    logic                     ld;

    if (i == DEPTH - 1) begin : g_last
      assign nbr = ctrl.load_data;
    end else begin : g_mid
      assign nbr = words[i+1];
    end

    // a push lands in the first free position
    assign ld = ctrl.load && (ctrl.load_idx == SIZE_W'(i));

    fqp_cell u_cell (
      .clk       (clk),
      .shift_en  (ctrl.shift),
      .load_en   (ld),
      .load_data (ctrl.load_data),
      .next_word (nbr),
      .word      (words[i])
    );
  end

  assign peek.w0 = words[0];
  assign peek.w1 = words[1];

endmodule

// ===== hw/rtl/fifo_queue_with_peek.sv =====
// fifo_queue_with_peek: top level of the fifo queue with front and back peek
// depends on fqp_pkg and fqp_chain (which uses fqp_cell)
//
// A queue of up to DEPTH (1024) signed 32-bit words kept in a row of cells, the oldest word in
// position 0. A push loads the first free cell, a pop moves every word one cell towards the
// front, and a query changes nothing. Every input transaction yields exactly one result
// transaction carrying the popped word (-1 unless a pop found a word), the size after the step,
// an empty flag, the front and back words (-1 when empty) and a flag for a push dropped on a full
// queue. One transaction is taken per clock cycle: the result is registered on the edge that takes the
// input, and the input side stalls only while that output register holds a result that
// the receiver is stalling. The back word is tracked in a register of its own, so no cell is read
// at a moving position. No clearing pass is needed after reset.
module fifo_queue_with_peek
  import fqp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  fqp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output fqp_out_t out_data
);

  logic [SIZE_W-1:0]        count_r, count_nxt;
  logic signed [WORD_W-1:0] back_r;
  logic                     out_valid_r;
  fqp_out_t                 out_r, res;

  logic      accept;
  logic      is_push, is_pop, empty_now, full_now;
  logic      do_push, do_pop;
  fqp_ctrl_t ctrl;
  fqp_peek_t peek;

  // a held result only blocks new input while the receiver stalls it
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign is_push   = (in_data.func == FUNC_PUSH);
  assign is_pop    = (in_data.func == FUNC_POP);
  assign empty_now = (count_r == '0);
  assign full_now  = (count_r == FULL_COUNT);
  assign do_push   = is_push && !full_now;
  assign do_pop    = is_pop && !empty_now;

  always_comb begin
    count_nxt = count_r;
    if (do_push) begin
      count_nxt = count_r + SIZE_W'(1);
    end else if (do_pop) begin
      count_nxt = count_r - SIZE_W'(1);
    end
  end

  // cell row control, only acted on for an accepted transaction
  assign ctrl.shift     = accept && do_pop;
  assign ctrl.load      = accept && do_push;
  assign ctrl.load_idx  = count_r;
  assign ctrl.load_data = in_data.data;

  fqp_chain u_chain (
    .clk  (clk),
    .ctrl (ctrl),
    .peek (peek)
  );

  // result as seen after this step
  always_comb begin
    res.pop_value = do_pop ? peek.w0 : NEG_ONE;
    res.size      = count_nxt;
    res.empty_res = (count_nxt == '0);
    res.dropped   = is_push && full_now;
    if (count_nxt == '0) begin
      res.front = NEG_ONE;
      res.back  = NEG_ONE;
    end else begin
      // front moves to position 1 on a pop, or is the new word on a push into an empty queue
      if (do_pop) begin
        res.front = peek.w1;
      end else if (do_push && empty_now) begin
        res.front = in_data.data;
      end else begin
        res.front = peek.w0;
      end
      res.back = do_push ? in_data.data : back_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= res;
      if (do_push) begin
        back_r <= in_data.data;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/fqp_checker.sv =====
// fqp_checker: port-level assertions for fifo_queue_with_peek, bound to the top level
// depends on fqp_pkg
module fqp_checker
  import fqp_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input fqp_out_t out_data
);

  // a stalled result transaction stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.empty_res == (out_data.size == '0))
    else $error("empty flag disagrees with size");

  a_empty_peek: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.empty_res |-> out_data.front == NEG_ONE && out_data.back == NEG_ONE)
    else $error("peek of empty queue not -1");

  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.size <= FULL_COUNT)
    else $error("size beyond depth");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.dropped |-> out_data.size == FULL_COUNT)
    else $error("push dropped while not full");

endmodule

bind fifo_queue_with_peek fqp_checker u_fqp_checker (.*);

// ===== test/tb_fifo_queue_with_peek.sv =====
// tb_fifo_queue_with_peek: self-checking testbench for the fifo queue with front and back peek
// depends on fqp_pkg and the fifo_queue_with_peek top level (with fqp_chain and fqp_cell)
module tb_fifo_queue_with_peek
  import fqp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // the selector value that the block has no operation for, handled as a query
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // watchdog, far above the slowest legal run of a few thousand transactions
  localparam int unsigned LIMIT_CYCLES = 400000;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     out_stall = 1'b0;
  fqp_in_t  in_data   = '0;
  logic     in_stall;
  logic     out_valid;
  fqp_out_t out_data;

  // shadow copy of the queue contents, oldest word first
  logic signed [WORD_W-1:0] shadow_words[$];
  // results predicted for accepted input transactions, oldest first
  fqp_out_t                 pending_results[$];

  int unsigned errors      = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned n_sent      = 0;
  int unsigned n_checked   = 0;
  int unsigned n_push      = 0;
  int unsigned n_pop       = 0;
  int unsigned n_query     = 0;
  int unsigned n_dropped   = 0;
  int unsigned n_empty_pop = 0;
  int unsigned peak_size   = 0;

  // sender burst shaping
  int unsigned burst_left  = 0;
  bit          idle_off    = 1'b0;

  // receiver stall pattern: a stall probability redrawn at the start of each phase
  int unsigned stall_pct   = 0;

  fifo_queue_with_peek dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles, %0d results still awaited", $realtime,
               cycle_cnt, pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: stall probability changes in phases, including stretches with no stall at all
  always @(posedge clk) begin
    if (cycle_cnt % 100 == 0) begin
      case ($urandom_range(4))
        0, 1:    stall_pct <= 0;
        2:       stall_pct <= 25;
        3:       stall_pct <= 50;
        default: stall_pct <= 90;
      endcase
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // predictor: apply one operation to the shadow queue and build the result it gives
  function automatic fqp_out_t queue_step(input fqp_in_t item);
    fqp_out_t r;
    r.pop_value = NEG_ONE;
    r.dropped   = 1'b0;
    case (item.func)
      FUNC_PUSH: begin
        n_push++;
        if (shadow_words.size() >= DEPTH) begin
          // full queue: word discarded, state untouched
          r.dropped = 1'b1;
          n_dropped++;
        end else begin
          shadow_words.push_back(item.data);
        end
      end
      FUNC_POP: begin
        n_pop++;
        if (shadow_words.size() != 0) begin
          r.pop_value = shadow_words.pop_front();
        end else begin
          n_empty_pop++;
        end
      end
      default: begin
        // query, and the spare selector that behaves as one
        n_query++;
      end
    endcase
    r.size      = SIZE_W'(shadow_words.size());
    r.empty_res = (shadow_words.size() == 0);
    if (shadow_words.size() != 0) begin
      r.front = shadow_words[0];
      r.back  = shadow_words[$];
    end else begin
      r.front = NEG_ONE;
      r.back  = NEG_ONE;
    end
    if (shadow_words.size() > peak_size) peak_size = shadow_words.size();
    return r;
  endfunction

  task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
                             input logic [WORD_W-1:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: result %0d field %s mismatch: expected %h actual %h", $realtime,
               n_checked, name, exp_v, act_v);
    end
  endtask

  task automatic compare_result(input fqp_out_t exp_r, input fqp_out_t act_r);
    check_field("pop_value", exp_r.pop_value, act_r.pop_value);
    check_field("size", WORD_W'(exp_r.size), WORD_W'(act_r.size));
    check_field("empty_res", WORD_W'(exp_r.empty_res), WORD_W'(act_r.empty_res));
    check_field("front", exp_r.front, act_r.front);
    check_field("back", exp_r.back, act_r.back);
    check_field("dropped", WORD_W'(exp_r.dropped), WORD_W'(act_r.dropped));
  endtask

  // both handshakes sampled in one process, on values from before the edge
  always @(posedge clk) begin
    fqp_out_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result transaction with nothing expected: expected none actual %h",
                   $realtime, out_data);
        end else begin
          exp_r = pending_results.pop_front();
          compare_result(exp_r, out_data);
        end
        n_checked++;
      end
      if (in_valid && !in_stall) begin
        pending_results.push_back(queue_step(in_data));
      end
    end
  end

  // random word, with the extremes of the signed range mixed in
  function automatic logic signed [WORD_W-1:0] rand_word();
    case ($urandom_range(11))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return NEG_ONE;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // send one transaction; valid stays high across a burst and drops only for a gap
  task automatic send_txn(input logic [1:0] func, input logic signed [WORD_W-1:0] data);
    fqp_in_t     item;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0 && !idle_off) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item.func = func;
    item.data = data;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  // empty queue corners, the spare selector and the extremes of the data word
  task automatic test_empty_corners();
    send_txn(FUNC_POP, rand_word());
    send_txn(FUNC_QUERY, rand_word());
    send_txn(FUNC_SPARE, rand_word());
    send_txn(FUNC_PUSH, 32'sh8000_0000);
    send_txn(FUNC_QUERY, '0);
    send_txn(FUNC_PUSH, 32'sh7fff_ffff);
    send_txn(FUNC_SPARE, NEG_ONE);
    send_txn(FUNC_PUSH, NEG_ONE);
    send_txn(FUNC_PUSH, '0);
    send_txn(FUNC_POP, '0);
    send_txn(FUNC_POP, NEG_ONE);
    send_txn(FUNC_QUERY, 32'sh7fff_ffff);
    send_txn(FUNC_POP, 32'sh8000_0000);
    // pop of the last word, so front and back fall back to -1
    send_txn(FUNC_POP, rand_word());
    send_txn(FUNC_POP, rand_word());
    send_txn(FUNC_PUSH, 32'sh0000_0001);
    send_txn(FUNC_POP, rand_word());
  endtask

  // fill to capacity, push into a full queue, pop and refill at the full mark, then drain
  task automatic test_fill_and_drop();
    repeat (DEPTH) send_txn(FUNC_PUSH, rand_word());
    repeat (4) send_txn(FUNC_PUSH, rand_word());
    send_txn(FUNC_QUERY, rand_word());
    send_txn(FUNC_SPARE, rand_word());
    repeat (3) begin
      send_txn(FUNC_POP, rand_word());
      send_txn(FUNC_PUSH, rand_word());
      send_txn(FUNC_PUSH, rand_word());
    end
    repeat (DEPTH + 2) send_txn(FUNC_POP, rand_word());
  endtask

  // random operations in phases of differing push weight, one phase with no sender gaps
  task automatic test_random_mix();
    int unsigned push_pct;
    int unsigned pick;
    logic [1:0]  func;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0:       push_pct = 80;
        1:       push_pct = 50;
        2:       push_pct = 20;
        default: push_pct = 55;
      endcase
      idle_off = (phase == 5);
      repeat (119) begin
        if ($urandom_range(99) < push_pct) begin
          func = FUNC_PUSH;
        end else begin
          pick = $urandom_range(9);
          func = (pick < 7) ? FUNC_POP : (pick < 9) ? FUNC_QUERY : FUNC_SPARE;
        end
        send_txn(func, rand_word());
      end
    end
    idle_off = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_corners();
    test_fill_and_drop();
    test_random_mix();

    // drain: wait for every predicted result, then keep watching for strays
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d transactions: %0d push (%0d dropped), %0d pop (%0d on empty), %0d query",
             n_sent, n_push, n_dropped, n_pop, n_empty_pop, n_query);
    $display("peak occupancy %0d of %0d words, %0d results checked, %0d mismatches",
             peak_size, DEPTH, n_checked, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
